>>> rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared widths, register indexes, reset values and state encoding for the
// binary mask centroid block.
// ----------------------------------------------------------------------------
package bmc_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int TALLY_W   = 21;
    localparam int SUM_W     = 30;
    localparam int COORD_W   = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT    = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 11'd320;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 11'd240;
    localparam logic [TALLY_W-1:0] MIN_COUNT_RST    = 21'd180;

    // Only this level counts as a white pixel
    localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;

    // Default frame size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Divider: one quotient bit per cycle over the full sum width
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Output transaction packing
    localparam int OUT_FIELD_W = 2 * COORD_W + TALLY_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIV_X,
        ST_DIV_Y
    } bmc_state_t;

endpackage

>>> rtl/binary_mask_centroid_top.sv
// ----------------------------------------------------------------------------
// binary_mask_centroid_top
// Accumulates the column and row sums and the count of white pixels of a
// raster-order frame and reports the truncated mean position per frame.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                 | Transaction
//  ---------+-----------+-----------------------------------------+--------------------
//  s_       | in        | tdata: pixel_value                      | s_tvalid & s_tready
//  m_       | out       | tdata: centroid_x, centroid_y,          | m_tvalid & m_tready
//           |           |        white_count; tuser: found        |
//  cfg_     | in        | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
//  Each pixel takes one cycle while s_tready is high. The last pixel of a frame
//  with enough white pixels starts the shared restoring divider, one quotient bit
//  per cycle, first for the column mean and then for the row mean: s_tready stays
//  low until both divisions are done. Without enough white pixels the result
//  appears on the next cycle with no stall. Apart from the divider, the last pixel
//  of a frame waits only while an earlier result is still held and not taken.
//  Reset is synchronous on aresetn low; configuration is always accepted.
// ----------------------------------------------------------------------------
module binary_mask_centroid_top
    import bmc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,    // [7:0] pixel_value

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [9:0] centroid_x, [19:10] centroid_y,
                                              // [40:20] white_count, rest zero
    output logic                  m_tuser,    // [0] found

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST_MAX = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);

    // Control and state registers
    bmc_state_t          state_reg,    state_next;
    logic [DIM_W-1:0]    fw_reg,       fw_next;
    logic [DIM_W-1:0]    fh_reg,       fh_next;
    logic [TALLY_W-1:0]  minc_reg,     minc_next;
    logic [COL_W-1:0]    col_pos_reg,  col_pos_next;
    logic [ROW_W-1:0]    row_pos_reg,  row_pos_next;
    logic [SUM_W-1:0]    col_sum_reg,  col_sum_next;
    logic [SUM_W-1:0]    row_sum_reg,  row_sum_next;
    logic [TALLY_W-1:0]  tally_reg,    tally_next;
    logic [STEP_W-1:0]   step_reg,     step_next;
    logic                m_valid_reg,  m_valid_next;

    // Payload registers
    logic [SUM_W-1:0]    quo_reg,      quo_next;
    logic [TALLY_W-1:0]  rem_reg,      rem_next;
    logic [TALLY_W-1:0]  dvsr_reg,     dvsr_next;
    logic [SUM_W-1:0]    ydvd_reg,     ydvd_next;
    logic [COORD_W-1:0]  cx_reg,       cx_next;
    logic [COORD_W-1:0]  m_x_reg,      m_x_next;
    logic [COORD_W-1:0]  m_y_reg,      m_y_next;
    logic [TALLY_W-1:0]  m_cnt_reg,    m_cnt_next;
    logic                m_found_reg,  m_found_next;

    // Frame geometry and pixel terms
    logic [COL_W-1:0]    col_last;
    logic [ROW_W-1:0]    row_last;
    logic                row_end;
    logic                frame_end;
    logic                white;
    logic                s_xfer;
    logic                out_free;
    logic [SUM_W-1:0]    col_sum_add;
    logic [SUM_W-1:0]    row_sum_add;
    logic [TALLY_W-1:0]  tally_add;
    logic                found_now;

    // Divider step
    logic [TALLY_W:0]    div_shift;
    logic [TALLY_W:0]    div_trial;
    logic                div_ge;
    logic [TALLY_W-1:0]  div_rem;
    logic [SUM_W-1:0]    div_quo;
    logic                div_last;

    // Clamp the configured size to one..maximum and take the last index
    always_comb begin
        priority if (fw_reg == '0) begin
            col_last = '0;
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            col_last = COL_LAST_MAX;
        end else begin
            col_last = COL_W'(fw_reg - DIM_W'(1));
        end
        priority if (fh_reg == '0) begin
            row_last = '0;
        end else if (32'(fh_reg) > 32'(MAX_HEIGHT)) begin
            row_last = ROW_LAST_MAX;
        end else begin
            row_last = ROW_W'(fh_reg - DIM_W'(1));
        end
    end

    assign row_end   = (col_pos_reg >= col_last);
    assign frame_end = row_end && (row_pos_reg >= row_last);
    assign out_free  = !m_valid_reg || m_tready;

    // Hold off the last pixel of a frame while the result register is busy
    assign s_tready  = (state_reg == ST_ACCUM) && (!frame_end || out_free);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Running sums including the pixel on the bus
    assign white       = (s_tdata == WHITE_LEVEL);
    assign col_sum_add = col_sum_reg + (white ? SUM_W'(col_pos_reg) : '0);
    assign row_sum_add = row_sum_reg + (white ? SUM_W'(row_pos_reg) : '0);
    assign tally_add   = tally_reg + (white ? TALLY_W'(1) : '0);
    assign found_now   = (tally_add > minc_reg);

    // Restoring division: shift in one dividend bit, subtract if it fits
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_trial = div_shift - {1'b0, dvsr_reg};
    assign div_ge    = (div_shift >= {1'b0, dvsr_reg});
    assign div_rem   = div_ge ? div_trial[TALLY_W-1:0] : div_shift[TALLY_W-1:0];
    assign div_quo   = {quo_reg[SUM_W-2:0], div_ge};
    assign div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));

    // Next state and datapath
    always_comb begin
        state_next   = state_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        minc_next    = minc_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        tally_next   = tally_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvsr_next    = dvsr_reg;
        ydvd_next    = ydvd_reg;
        cx_next      = cx_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_cnt_next   = m_cnt_reg;
        m_found_next = m_found_reg;

        // Drop the result once the output transaction completes
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Register writes; unknown indexes are ignored
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_next   = cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: fh_next   = cfg_data[DIM_W-1:0];
                REG_MIN_COUNT:    minc_next = cfg_data[TALLY_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_ACCUM: begin
                if (s_xfer) begin
                    if (frame_end) begin
                        // Close the frame and restart the sums
                        col_pos_next = '0;
                        row_pos_next = '0;
                        col_sum_next = '0;
                        row_sum_next = '0;
                        tally_next   = '0;
                        m_cnt_next   = tally_add;
                        m_found_next = found_now;
                        if (found_now) begin
                            quo_next   = col_sum_add;
                            ydvd_next  = row_sum_add;
                            dvsr_next  = tally_add;
                            rem_next   = '0;
                            step_next  = '0;
                            state_next = ST_DIV_X;
                        end else begin
                            m_x_next     = '0;
                            m_y_next     = '0;
                            m_valid_next = 1'b1;
                        end
                    end else begin
                        col_sum_next = col_sum_add;
                        row_sum_next = row_sum_add;
                        tally_next   = tally_add;
                        if (row_end) begin
                            col_pos_next = '0;
                            row_pos_next = row_pos_reg + ROW_W'(1);
                        end else begin
                            col_pos_next = col_pos_reg + COL_W'(1);
                        end
                    end
                end
            end
            ST_DIV_X: begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (div_last) begin
                    // Keep the column mean, start on the row sum
                    cx_next    = div_quo[COORD_W-1:0];
                    quo_next   = ydvd_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (div_last) begin
                    m_x_next     = cx_reg;
                    m_y_next     = div_quo[COORD_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            fw_reg      <= FRAME_WIDTH_RST;
            fh_reg      <= FRAME_HEIGHT_RST;
            minc_reg    <= MIN_COUNT_RST;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            tally_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            minc_reg    <= minc_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
            tally_reg   <= tally_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvsr_reg    <= dvsr_next;
        ydvd_reg    <= ydvd_next;
        cx_reg      <= cx_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_cnt_reg   <= m_cnt_next;
        m_found_reg <= m_found_next;
    end

    // Output packing
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_cnt_reg, m_y_reg, m_x_reg});
    assign m_tuser  = m_found_reg;

endmodule

>>> sim/binary_mask_centroid_top_test.sv
// ----------------------------------------------------------------------------
// binary_mask_centroid_top_test
// Self-checking bench for the binary mask centroid block. Pixels are streamed
// in raster order from a backlog. A behavioural predictor follows every
// accepted pixel and queues the per-frame centroid, count and found flag.
// The monitor compares each output transaction with the oldest queued frame
// result. Directed frames cover degenerate and oversized frame sizes, the
// found threshold boundary, the largest centroids and size changes mid-frame.
// Random frames follow under three idling patterns and one long output stall.
// ----------------------------------------------------------------------------
module binary_mask_centroid_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmc_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES = 2 * DIV_STEPS + 16;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 540;

    // Index beyond the register list: writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] centroid_x;
        logic [COORD_W-1:0] centroid_y;
        logic [TALLY_W-1:0] white_count;
        logic               found;
    } frame_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Stimulus bookkeeping
    logic [PIX_W-1:0] pixel_backlog[$];
    frame_result_t    centroid_expected[$];
    int unsigned      pixels_queued   = 0;
    int unsigned      pixels_accepted = 0;
    int unsigned      mismatch_count  = 0;
    int unsigned      cycle_count     = 0;
    int unsigned      send_idle_pct   = 0;
    int unsigned      recv_idle_pct   = 0;
    logic             hold_request    = 1'b0;
    logic             hold_done       = 1'b0;
    int unsigned      hold_left       = 0;

    // Predictor copy of the registers and the frame accumulators
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [TALLY_W-1:0] cfg_min;
    logic [COORD_W-1:0] col_at;
    logic [COORD_W-1:0] row_at;
    logic [SUM_W-1:0]   col_total;
    logic [SUM_W-1:0]   row_total;
    logic [TALLY_W-1:0] white_tally;

    binary_mask_centroid_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] pixel_value
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [9:0] centroid_x, [19:10] centroid_y,
                                  // [40:20] white_count, rest zero
        .m_tuser   (m_tuser),     // [0] found
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A zero size acts as one, an oversized one as the maximum
    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    task automatic clear_frame();
        col_at      = '0;
        row_at      = '0;
        col_total   = '0;
        row_total   = '0;
        white_tally = '0;
    endtask

    // Advance the frame by one pixel and queue a result on the last pixel
    task automatic absorb_pixel(input logic [PIX_W-1:0] pix);
        int unsigned   w;
        int unsigned   h;
        logic          row_end;
        logic          frame_end;
        frame_result_t res;
        w = effective_dim(cfg_width, MAX_W);
        h = effective_dim(cfg_height, MAX_H);
        if (pix == WHITE_LEVEL) begin
            col_total   = col_total + SUM_W'(col_at);
            row_total   = row_total + SUM_W'(row_at);
            white_tally = white_tally + 1'b1;
        end
        row_end   = (col_at >= w - 1);
        frame_end = row_end && (row_at >= h - 1);
        if (frame_end) begin
            res.found       = (white_tally > cfg_min);
            res.centroid_x  = '0;
            res.centroid_y  = '0;
            res.white_count = white_tally;
            if (res.found && white_tally != 0) begin
                res.centroid_x = COORD_W'(col_total / white_tally);
                res.centroid_y = COORD_W'(row_total / white_tally);
            end
            centroid_expected.push_back(res);
            clear_frame();
        end else if (row_end) begin
            col_at = '0;
            row_at = row_at + 1'b1;
        end else begin
            col_at = col_at + 1'b1;
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_MIN_COUNT:    cfg_min    = value[TALLY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (centroid_expected.size() == 0) begin
            $display("%0t: result with none expected: tdata %h, tuser %b",
                     $time, m_tdata, m_tuser);
            mismatch_count++;
        end else begin
            want = centroid_expected.pop_front();
            compare_field("centroid_x", 32'(want.centroid_x),
                          32'(m_tdata[COORD_W-1:0]));
            compare_field("centroid_y", 32'(want.centroid_y),
                          32'(m_tdata[2*COORD_W-1:COORD_W]));
            compare_field("white_count", 32'(want.white_count),
                          32'(m_tdata[OUT_FIELD_W-1:2*COORD_W]));
            compare_field("found", 32'(want.found), 32'(m_tuser));
            compare_field("tdata padding", 32'(0),
                          32'(m_tdata[OUT_DATA_W-1:OUT_FIELD_W]));
        end
    endtask

    // Pixel driver: predict on each accepted transaction, refill the slot
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_pixel(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pixel_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, started once on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL binary_mask_centroid_top");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] v);
        pixel_backlog.push_back(v);
        pixels_queued++;
    endtask

    function automatic logic [PIX_W-1:0] random_pixel(input int unsigned white_pct);
        if ($urandom_range(99) < white_pct) return WHITE_LEVEL;
        return PIX_W'($urandom_range(0, 254));
    endfunction

    task automatic queue_pixels(input int unsigned count, input int unsigned white_pct);
        repeat (count) queue_pixel(random_pixel(white_pct));
    endtask

    // Wait until every pixel is taken and every result is in, then let the
    // divider run out before touching the registers
    task automatic settle();
        do @(posedge aclk);
        while (pixels_accepted != pixels_queued || centroid_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return DIM_W'($urandom_range(9, 16));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(0, 4))
            0:       return 100;
            1:       return 0;
            2:       return 50;
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    // Random settings, each followed by whole frames and now and then a
    // partial frame that runs on under the next setting
    task automatic run_phase(input int unsigned budget);
        logic [DIM_W-1:0]   w_val;
        logic [DIM_W-1:0]   h_val;
        logic [TALLY_W-1:0] min_val;
        int unsigned        area;
        int unsigned        spent;
        int unsigned        extra;
        spent = 0;
        while (spent < budget) begin
            w_val = pick_dim();
            h_val = pick_dim();
            area  = effective_dim(w_val, MAX_W) * effective_dim(h_val, MAX_H);
            case ($urandom_range(0, 7))
                0:       min_val = '0;
                1:       min_val = '1;
                default: min_val = TALLY_W'($urandom_range(0, area));
            endcase
            write_register(REG_FRAME_WIDTH, {10'($urandom()), w_val});
            write_register(REG_FRAME_HEIGHT, {10'($urandom()), h_val});
            write_register(REG_MIN_COUNT, min_val);
            if ($urandom_range(0, 9) == 0) write_register(REG_UNUSED, CFG_DATA_W'($urandom()));
            repeat ($urandom_range(1, 5)) begin
                queue_pixels(area, pick_density());
                spent += area;
            end
            if ($urandom_range(0, 5) == 0) begin
                extra = $urandom_range(1, area);
                queue_pixels(extra, pick_density());
                spent += extra;
            end
            settle();
        end
    endtask

    initial begin
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        cfg_min    = MIN_COUNT_RST;
        clear_frame();
        send_idle_pct <= 6;
        recv_idle_pct <= 66;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Unknown index, then a zero frame size carried in masked-off data:
        // every pixel is a whole frame
        write_register(REG_UNUSED, '1);
        write_register(REG_FRAME_WIDTH, 21'h1FF800);
        write_register(REG_FRAME_HEIGHT, '0);
        write_register(REG_MIN_COUNT, '0);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd254);
        queue_pixel(8'd127);
        queue_pixel(8'd128);
        queue_pixel(8'd1);
        queue_pixel(8'd85);
        queue_pixel(8'd170);
        queue_pixel(8'd255);
        settle();

        // Found threshold: largest minimum, then tally equal to and above it
        write_register(REG_FRAME_WIDTH, 21'd2);
        write_register(REG_FRAME_HEIGHT, 21'd2);
        write_register(REG_MIN_COUNT, '1);
        queue_pixels(4, 100);
        settle();
        write_register(REG_MIN_COUNT, 21'd3);
        queue_pixel(8'd0);
        queue_pixels(3, 100);
        queue_pixels(4, 100);
        settle();

        // Oversized width acts as the maximum: largest column centroid
        write_register(REG_FRAME_WIDTH, 21'd1500);
        write_register(REG_FRAME_HEIGHT, 21'd1);
        write_register(REG_MIN_COUNT, '0);
        queue_pixels(MAX_W - 1, 0);
        queue_pixel(WHITE_LEVEL);
        settle();

        // Tallest frame: largest row centroid
        write_register(REG_FRAME_WIDTH, 21'd1);
        write_register(REG_FRAME_HEIGHT, 21'd1024);
        queue_pixels(MAX_H - 1, 0);
        queue_pixel(WHITE_LEVEL);
        settle();

        // Shrink the width and then the height part way through a frame
        write_register(REG_FRAME_WIDTH, 21'd1024);
        write_register(REG_FRAME_HEIGHT, 21'd2047);
        queue_pixel(8'd255);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        settle();
        write_register(REG_FRAME_WIDTH, 21'd2);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd255);
        settle();
        write_register(REG_FRAME_HEIGHT, 21'd1);
        queue_pixel(8'd255);
        queue_pixel(8'd255);
        settle();

        // Random frames: sender mostly busy, receiver mostly stalling
        run_phase(PHASE_ITEMS);

        // Swap the idling of the two sides
        send_idle_pct <= 66;
        recv_idle_pct <= 6;
        run_phase(PHASE_ITEMS);

        // No idling, with one long receiver hold-off to back the block up
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_request  <= 1'b1;
        run_phase(PHASE_ITEMS);

        if (centroid_expected.size() != 0) begin
            $display("%0t: %0d frame results never arrived", $time, centroid_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS binary_mask_centroid_top");
        end else begin
            $display("FAIL binary_mask_centroid_top");
        end
        $finish;
    end

endmodule
